@@ src/jerk_limited_velocity_profile_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the jerk-limited velocity profile
// Two property forms, same-cycle and next-cycle implication, sampled on clk
// and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef JERK_LIMITED_VELOCITY_PROFILE_ASSERT_SVH
`define JERK_LIMITED_VELOCITY_PROFILE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define JLVP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define JLVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/jlvp_pkg.sv @@
// ----------------------------------------------------------------------------
// jlvp_pkg
// Widths, register indexes, reset values and sequencer codes of the
// jerk-limited velocity profile.
// ----------------------------------------------------------------------------
package jlvp_pkg;

  localparam int POS_W     = 48;
  localparam int VAL_W     = 32;
  localparam int VEL_W     = 31;
  localparam int DT_W      = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ACCEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_JERK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_JERK    = 3'd5;

  localparam logic [15:0] TIME_STEP_RST = 16'd6554;
  localparam logic [30:0] INV_STEP_RST  = 31'd655350;
  localparam logic [31:0] MIN_ACCEL_RST = 32'hFFFD_0000;
  localparam logic [30:0] MAX_ACCEL_RST = 31'd65536;
  localparam logic [31:0] MIN_JERK_RST  = 32'hFFFF_0000;
  localparam logic [30:0] MAX_JERK_RST  = 31'd65536;

  // 1/6 in Q0.16
  localparam logic [15:0] SIXTH_Q16 = 16'd10923;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_TAIL,
    ST_FINISH
  } state_t;

  // one code per product, issued in this order
  typedef enum logic [3:0] {
    OP_DD,
    OP_DES,
    OP_D3,
    OP_JERK,
    OP_SD3,
    OP_VDT,
    OP_AHD2,
    OP_JSD3,
    OP_ADT,
    OP_JHD2,
    OP_JDT
  } op_t;

endpackage

@@ src/jerk_limited_velocity_profile.sv @@
// ----------------------------------------------------------------------------
// jerk_limited_velocity_profile
// A load beat (action 0) sets position, velocity and acceleration when it is
// taken and returns nothing. A step beat (action 1) carries a velocity cap and
// returns the new position, velocity, acceleration and the applied jerk. A
// step runs eleven products through one shared 33x32 multiplier, one per
// cycle, with a registered product feeding rounding, the clamps and one shared
// adder; the input side stays not ready until the step has finished. The
// result sits in an output register, so the next beat is taken while it
// waits; a following step holds in its finish state until that register
// is free. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`include "jerk_limited_velocity_profile_assert.svh"

module jerk_limited_velocity_profile (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [jlvp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [jlvp_pkg::VAL_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   action,
  input  logic signed [jlvp_pkg::VAL_W-1:0]      cap_velocity,
  input  logic signed [jlvp_pkg::POS_W-1:0]      init_position,
  input  logic signed [jlvp_pkg::VAL_W-1:0]      init_velocity,
  input  logic signed [jlvp_pkg::VAL_W-1:0]      init_accel,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [jlvp_pkg::POS_W-1:0]      position,
  output logic [jlvp_pkg::VEL_W-1:0]             velocity,
  output logic signed [jlvp_pkg::VAL_W-1:0]      acceleration,
  output logic signed [jlvp_pkg::VAL_W-1:0]      jerk
);

  import jlvp_pkg::*;

  localparam logic signed [64:0] HALF16     = 65'sd32768;
  localparam logic signed [64:0] HALF17     = 65'sd65536;
  localparam logic signed [49:0] POS_MAX_X  = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] POS_MIN_X  = 50'sh3_8000_0000_0000;

  // lower bound first, then upper bound wins
  function automatic logic signed [31:0] clamp32(input logic signed [49:0] x,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [49:0] t;
    logic signed [49:0] lo_x;
    logic signed [49:0] hi_x;
    lo_x = {{18{lo[31]}}, lo};
    hi_x = {{18{hi[31]}}, hi};
    t = x;
    if (t < lo_x) t = lo_x;
    if (t > hi_x) t = hi_x;
    return t[31:0];
  endfunction

  // configuration
  logic [15:0]        time_step;
  logic [30:0]        inverse_time_step;
  logic signed [31:0] acc_floor;
  logic [30:0]        acc_ceil;
  logic signed [31:0] jerk_floor;
  logic [30:0]        jerk_ceil;
  logic signed [31:0] max_acc_s;
  logic signed [31:0] jerk_ceil_s;

  // sequencer
  state_t state, state_next;
  op_t    mul_op, mul_op_next;
  logic   in_acc;
  logic   fin_go;

  // state and step working registers
  logic signed [47:0] cur_position;
  logic signed [31:0] cur_velocity;
  logic signed [31:0] cur_accel;
  logic [30:0]        cap_r;
  logic [15:0]        hd2, d2, d3, sd3;
  logic signed [31:0] desired_r;
  logic signed [31:0] jerk_r;
  logic signed [49:0] ns_acc;
  logic signed [34:0] nv_acc;
  logic signed [33:0] na_acc;

  // shared multiplier and post stage
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  op_t                p_op;
  logic               p_vld;
  logic signed [64:0] r16_full, r17_full;
  logic signed [49:0] r16;
  logic signed [49:0] add_base, add_sum;

  // final clamps
  logic signed [47:0] ns_sat, ns_fin;
  logic [30:0]        nv_sat, nv_fin;
  logic signed [31:0] na_clamp, na_fin;
  logic               capped;

  assign cfg_ready   = 1'b1;
  assign max_acc_s   = $signed({1'b0, acc_ceil});
  assign jerk_ceil_s = $signed({1'b0, jerk_ceil});

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step         <= TIME_STEP_RST;
      inverse_time_step <= INV_STEP_RST;
      acc_floor         <= MIN_ACCEL_RST;
      acc_ceil          <= MAX_ACCEL_RST;
      jerk_floor        <= MIN_JERK_RST;
      jerk_ceil         <= MAX_JERK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIME_STEP: time_step         <= cfg_data[15:0];
        REG_INV_STEP:  inverse_time_step <= cfg_data[30:0];
        REG_MIN_ACCEL: acc_floor         <= cfg_data;
        REG_MAX_ACCEL: acc_ceil          <= cfg_data[30:0];
        REG_MIN_JERK:  jerk_floor        <= cfg_data;
        REG_MAX_JERK:  jerk_ceil         <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_acc = in_valid && in_ready;
  assign fin_go = (state == ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mul_op <= OP_DD;
      p_vld  <= 1'b0;
    end else begin
      state  <= state_next;
      mul_op <= mul_op_next;
      p_vld  <= (state == ST_MUL);
    end
  end

  always_comb begin
    state_next  = state;
    mul_op_next = mul_op;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && action) begin
          state_next  = ST_MUL;
          mul_op_next = OP_DD;
        end
      end
      ST_MUL: begin
        if (mul_op == OP_JDT) begin
          state_next = ST_TAIL;
        end else begin
          mul_op_next = op_t'(4'(mul_op) + 4'd1);
        end
      end
      ST_TAIL: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Multiplier operand select
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (mul_op)
      OP_DD: begin
        mul_a = $signed({17'd0, time_step});
        mul_b = $signed({16'd0, time_step});
      end
      OP_DES: begin
        mul_a = $signed({2'b00, cap_r}) - $signed({cur_velocity[31], cur_velocity});
        mul_b = $signed({1'b0, inverse_time_step});
      end
      OP_D3: begin
        mul_a = $signed({17'd0, d2});
        mul_b = $signed({16'd0, time_step});
      end
      OP_JERK: begin
        mul_a = $signed({desired_r[31], desired_r}) - $signed({cur_accel[31], cur_accel});
        mul_b = $signed({1'b0, inverse_time_step});
      end
      OP_SD3: begin
        mul_a = $signed({17'd0, d3});
        mul_b = $signed({16'd0, SIXTH_Q16});
      end
      OP_VDT: begin
        mul_a = $signed({cur_velocity[31], cur_velocity});
        mul_b = $signed({16'd0, time_step});
      end
      OP_AHD2: begin
        mul_a = $signed({cur_accel[31], cur_accel});
        mul_b = $signed({16'd0, hd2});
      end
      OP_JSD3: begin
        mul_a = $signed({jerk_r[31], jerk_r});
        mul_b = $signed({16'd0, sd3});
      end
      OP_ADT: begin
        mul_a = $signed({cur_accel[31], cur_accel});
        mul_b = $signed({16'd0, time_step});
      end
      OP_JHD2: begin
        mul_a = $signed({jerk_r[31], jerk_r});
        mul_b = $signed({16'd0, hd2});
      end
      OP_JDT: begin
        mul_a = $signed({jerk_r[31], jerk_r});
        mul_b = $signed({16'd0, time_step});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    p_op <= mul_op;
  end

  // --------------------------------------------------------------------------
  // Post stage: round, then clamp or accumulate through one adder
  // --------------------------------------------------------------------------
  assign r16_full = (prod + HALF16) >>> 16;
  assign r17_full = (prod + HALF17) >>> 17;
  assign r16      = r16_full[49:0];

  always_comb begin
    unique case (p_op)
      OP_VDT:           add_base = {{2{cur_position[47]}}, cur_position};
      OP_AHD2, OP_JSD3: add_base = ns_acc;
      OP_ADT:           add_base = {{18{cur_velocity[31]}}, cur_velocity};
      OP_JHD2:          add_base = {{15{nv_acc[34]}}, nv_acc};
      OP_JDT:           add_base = {{18{cur_accel[31]}}, cur_accel};
      default:          add_base = '0;
    endcase
  end

  assign add_sum = add_base + r16;

  always_ff @(posedge clk) begin
    if (p_vld) begin
      case (p_op)
        OP_DD: begin
          hd2 <= r17_full[15:0];
          d2  <= r16_full[15:0];
        end
        OP_DES:                   desired_r <= clamp32(r16, acc_floor, max_acc_s);
        OP_D3:                    d3        <= r16[15:0];
        OP_JERK:                  jerk_r    <= clamp32(r16, jerk_floor, jerk_ceil_s);
        OP_SD3:                   sd3       <= r16[15:0];
        OP_VDT, OP_AHD2, OP_JSD3: ns_acc    <= add_sum;
        OP_ADT, OP_JHD2:          nv_acc    <= add_sum[34:0];
        OP_JDT:                   na_acc    <= add_sum[33:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Final saturation, cap and monotonic position
  // --------------------------------------------------------------------------
  always_comb begin
    if (ns_acc < POS_MIN_X) begin
      ns_sat = POS_MIN_X[47:0];
    end else if (ns_acc > POS_MAX_X) begin
      ns_sat = POS_MAX_X[47:0];
    end else begin
      ns_sat = ns_acc[47:0];
    end
    ns_fin = (ns_sat < cur_position) ? cur_position : ns_sat;

    if (nv_acc[34]) begin
      nv_sat = '0;
    end else if (nv_acc[33:31] != 3'd0) begin
      nv_sat = '1;
    end else begin
      nv_sat = nv_acc[30:0];
    end
    capped = (nv_sat > cap_r);
    nv_fin = capped ? cap_r : nv_sat;

    na_clamp = clamp32({{16{na_acc[33]}}, na_acc}, acc_floor, max_acc_s);
    // when capped, drop any positive acceleration
    na_fin = (capped && !na_clamp[31]) ? '0 : na_clamp;
  end

  // --------------------------------------------------------------------------
  // Architectural state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_position <= '0;
      cur_velocity <= '0;
      cur_accel    <= '0;
    end else if (in_acc && !action) begin
      cur_position <= init_position;
      cur_velocity <= init_velocity;
      cur_accel    <= init_accel;
    end else if (fin_go) begin
      cur_position <= ns_fin;
      cur_velocity <= $signed({1'b0, nv_fin});
      cur_accel    <= na_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && action) begin
      cap_r <= cap_velocity[31] ? '0 : cap_velocity[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      position     <= ns_fin;
      velocity     <= nv_fin;
      acceleration <= na_fin;
      jerk         <= jerk_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `JLVP_ASSERT_IMPL(a_out_from_finish, $rose(out_valid), $past(state) == ST_FINISH, "result beat not from finish")
  `JLVP_ASSERT_IMPL(a_post_in_run, p_vld, state == ST_MUL || state == ST_TAIL, "product outside a step")
  `JLVP_ASSERT_IMPL(a_tail_last_op, state == ST_TAIL, p_op == OP_JDT, "tail reached before last product")
  `JLVP_ASSERT_NEXT(a_pos_monotonic, fin_go, cur_position >= $past(cur_position), "position went back")
  `JLVP_ASSERT_NEXT(a_busy_after_step, in_acc && action, !in_ready, "ready during a step")

endmodule
